/* hdl/xcdfd_pkg.sv */
// Package for the dual frame deframer: request kinds, status codes, start bytes
// and frame layout constants, plus parameter defaults.
// No dependencies.
package xcdfd_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_READ    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_DATA_READY = 3'd0,
      ST_CTRL_READY = 3'd1,
      ST_BAD_SUM    = 3'd2,
      ST_NO_SLOT    = 3'd3,
      ST_TOO_LONG   = 3'd4,
      ST_READ_DATA  = 3'd5
   } status_type;

   localparam logic [7:0] START_DATA = 8'hAE;
   localparam logic [7:0] START_CTRL = 8'hBD;

   // Framing overhead in bytes and the header positions within a frame.
   localparam int DATA_OVERHEAD = 10;
   localparam int CTRL_OVERHEAD = 4;
   localparam logic [8:0] POS_ADDR_FIRST = 9'd1;
   localparam logic [8:0] POS_ADDR_LAST  = 9'd4;
   localparam logic [8:0] POS_PROG_LO    = 9'd5;
   localparam logic [8:0] POS_PROG_HI    = 9'd6;
   localparam logic [8:0] POS_DATA_LEN   = 9'd8;
   localparam logic [8:0] POS_CTRL_CMD   = 9'd1;
   localparam logic [8:0] POS_CTRL_LEN   = 9'd2;

   localparam int MAX_PAYLOAD_DEFAULT = 128;
   localparam int CONTROL_MAX_DEFAULT = 32;
   localparam int SLOT_COUNT_DEFAULT  = 4;

endpackage

/* hdl/xor_checked_dual_frame_deframer_unit.sv */
// Top level of the dual frame deframer: byte parser, slot store and result pipeline.
// Depends on xcdfd_pkg.
//
// Results: a request that gives a result passes the middle stage, then the output register;
// it may wait in either while rsp_ready is low. rsp_valid rises once it reaches the latter.
// Throughput: one request per cycle while req_ready is high; each byte updates the parser
// state in a single pass. The store read port is registered.
// Reset clears the parser, the slot mask, the current slot and the pipeline valid bits.
// The frame store has no reset and no clearing pass; only written bytes are meaningful.
module xor_checked_dual_frame_deframer_unit #(
   parameter int MAX_PAYLOAD = xcdfd_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int CONTROL_MAX = xcdfd_pkg::CONTROL_MAX_DEFAULT,
   parameter int SLOT_COUNT  = xcdfd_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [1:0]  req_read_slot,
   input  logic [7:0]  req_read_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_program_id,
   output logic [7:0]  rsp_payload_len,
   output logic [1:0]  rsp_frame_slot,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_read_byte
);
   import xcdfd_pkg::*;

   // Each slot holds a whole data frame, so the payload never overruns it.
   localparam int SLOT_BYTES  = MAX_PAYLOAD + DATA_OVERHEAD;
   localparam int STORE_DEPTH = SLOT_COUNT * SLOT_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [8:0] DATA_BOUND = 9'(DATA_OVERHEAD + MAX_PAYLOAD);
   localparam logic [8:0] CTRL_BOUND = 9'(CTRL_OVERHEAD + CONTROL_MAX);

   // A result on its way from the parser stage to the output register.
   typedef struct packed {
      status_type  status;
      logic [31:0] dest_address;
      logic [15:0] program_id;
      logic [7:0]  payload_len;
      logic [1:0]  frame_slot;
      logic [7:0]  command;
      logic        is_read;
      logic        read_zero;
   } result_type;

   // Parser state.
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [8:0]            count_ff, count_in;
   logic [8:0]            total_ff, total_in;
   logic                  ctrl_ff, ctrl_in;
   logic [7:0]            xor_ff, xor_in;
   logic [31:0]           addr_ff, addr_in;
   logic [15:0]           prog_ff, prog_in;
   logic [7:0]            len_ff, len_in;
   logic [7:0]            cmd_ff, cmd_in;

   // Slot store.
   logic [7:0]        store_mem [STORE_DEPTH];
   logic [7:0]        store_rd_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic              rd_ok;
   logic [ADDR_W-1:0] rd_addr;

   // Result pipeline: a middle stage that waits for the store read, then the output register.
   logic       mid_valid_ff, mid_valid_in;
   result_type mid_ff, mid_in;
   logic       has_result;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_free;
   logic       mid_move;
   logic       accept;

   // The output register frees up when it is empty or its request is being taken,
   // and the middle stage accepts a new request whenever it is empty or can hand its own on.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign mid_move  = mid_valid_ff && out_free;
   assign req_ready = !mid_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // Read address checks: slots beyond the store and offsets beyond a slot read as zero.
   assign rd_ok   = (32'(req_read_slot) < 32'(SLOT_COUNT)) &&
                    (32'(req_read_offset) < 32'(SLOT_BYTES));
   assign rd_addr = ADDR_W'(ADDR_W'(req_read_slot) * ADDR_W'(SLOT_BYTES)) +
                    ADDR_W'(req_read_offset);
   assign rd_en   = accept && (kind_type'(req_kind) == KIND_READ) && rd_ok;

   // Parser: the whole state update for one request in a single pass.
   always_comb begin
      logic [8:0]            pos;
      logic [7:0]            b;
      logic [SLOT_COUNT-1:0] mask_set;
      logic [SLOT_W-1:0]     free_idx;
      logic                  free_found;
      logic [8:0]            bound;
      status_type            st;

      pos        = count_ff;
      b          = req_rx_byte;
      mask_set   = used_ff | (SLOT_COUNT'(1) << slot_ff);
      free_idx   = '0;
      free_found = 1'b0;
      bound      = '0;
      st         = ST_READ_DATA;

      slot_in  = slot_ff;
      used_in  = used_ff;
      count_in = count_ff;
      total_in = total_ff;
      ctrl_in  = ctrl_ff;
      xor_in   = xor_ff;
      addr_in  = addr_ff;
      prog_in  = prog_ff;
      len_in   = len_ff;
      cmd_in   = cmd_ff;

      has_result = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(ADDR_W'(slot_ff) * ADDR_W'(SLOT_BYTES)) + ADDR_W'(pos);

      // Lowest free slot once the current one is claimed.
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!mask_set[i]) begin
            free_idx   = SLOT_W'(i);
            free_found = 1'b1;
         end
      end

      case (kind_type'(req_kind))
         KIND_BYTE: begin
            if (pos == 9'd0) begin
               // Hunting: only a start byte opens a frame.
               if ((b == START_DATA) || (b == START_CTRL)) begin
                  ctrl_in  = (b == START_CTRL);
                  xor_in   = '0;
                  total_in = '0;
                  addr_in  = '0;
                  prog_in  = '0;
                  len_in   = '0;
                  cmd_in   = '0;
                  count_in = 9'd1;
                  wr_en    = 1'b1;
               end
            end else begin
               // Bytes past the end of a slot are not stored.
               wr_en    = (32'(pos) < 32'(SLOT_BYTES));
               count_in = pos + 9'd1;
               if (total_ff == 9'd0) begin
                  // Header bytes.
                  if (!ctrl_ff) begin
                     if ((pos >= POS_ADDR_FIRST) && (pos <= POS_ADDR_LAST)) begin
                        addr_in[8*(2'(pos - 9'd1)) +: 8] = b;
                     end else if (pos == POS_PROG_LO) begin
                        prog_in[7:0] = b;
                     end else if (pos == POS_PROG_HI) begin
                        prog_in[15:8] = b;
                     end else if (pos == POS_DATA_LEN) begin
                        len_in   = b;
                        total_in = 9'(DATA_OVERHEAD) + 9'(b);
                     end
                  end else begin
                     if (pos == POS_CTRL_CMD) begin
                        cmd_in = b;
                     end else if (pos == POS_CTRL_LEN) begin
                        len_in   = b;
                        total_in = 9'(CTRL_OVERHEAD) + 9'(b);
                     end
                  end
                  xor_in = xor_ff ^ b;
                  bound  = ctrl_ff ? CTRL_BOUND : DATA_BOUND;
                  if ((total_in != 9'd0) && (total_in > bound)) begin
                     // Oversized frame: dropped as soon as its length is known.
                     st         = ST_TOO_LONG;
                     has_result = 1'b1;
                     count_in   = '0;
                     total_in   = '0;
                  end
               end else if ((pos + 9'd1) < total_ff) begin
                  xor_in = xor_ff ^ b;
               end else begin
                  // Checksum byte closes the frame.
                  count_in   = '0;
                  total_in   = '0;
                  has_result = 1'b1;
                  if (xor_ff != b) begin
                     st = ST_BAD_SUM;
                  end else if (ctrl_ff) begin
                     st = ST_CTRL_READY;
                  end else if (free_found) begin
                     st      = ST_DATA_READY;
                     used_in = mask_set;
                     slot_in = free_idx;
                  end else begin
                     // No slot left: the claim is undone and the slot is reused.
                     st = ST_NO_SLOT;
                  end
               end
            end
         end
         KIND_RELEASE: begin
            used_in = '0;
         end
         KIND_READ: begin
            has_result = 1'b1;
            st         = ST_READ_DATA;
         end
         default: begin
         end
      endcase

      // Result fields use the header values as updated by this byte.
      mid_in.status       = st;
      mid_in.is_read      = (st == ST_READ_DATA);
      mid_in.read_zero    = !rd_ok;
      mid_in.frame_slot   = mid_in.is_read ? 2'd0 : 2'(slot_ff);
      mid_in.payload_len  = mid_in.is_read ? 8'd0 : len_in;
      mid_in.dest_address = (mid_in.is_read || ctrl_in) ? 32'd0 : addr_in;
      mid_in.program_id   = (mid_in.is_read || ctrl_in) ? 16'd0 : prog_in;
      mid_in.command      = (!mid_in.is_read && ctrl_in) ? cmd_in : 8'd0;
   end

   always_comb begin
      if (accept) begin
         mid_valid_in = has_result;
      end else if (mid_move) begin
         mid_valid_in = 1'b0;
      end else begin
         mid_valid_in = mid_valid_ff;
      end

      if (mid_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      out_in      = mid_ff;
      out_byte_in = (mid_ff.is_read && !mid_ff.read_zero) ? store_rd_ff : 8'd0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         ctrl_ff      <= 1'b0;
         xor_ff       <= '0;
         addr_ff      <= '0;
         prog_ff      <= '0;
         len_ff       <= '0;
         cmd_ff       <= '0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            slot_ff  <= slot_in;
            used_ff  <= used_in;
            count_ff <= count_in;
            total_ff <= total_in;
            ctrl_ff  <= ctrl_in;
            xor_ff   <= xor_in;
            addr_ff  <= addr_in;
            prog_ff  <= prog_in;
            len_ff   <= len_in;
            cmd_ff   <= cmd_in;
         end
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         mid_ff <= mid_in;
      end
      if (mid_move) begin
         out_ff      <= out_in;
         out_byte_ff <= out_byte_in;
      end
   end

   // Slot store: one write and one registered read port. The read data holds
   // while the middle stage stalls, since no request is accepted meanwhile.
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         store_mem[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         store_rd_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_dest_address = out_ff.dest_address;
   assign rsp_program_id   = out_ff.program_id;
   assign rsp_payload_len  = out_ff.payload_len;
   assign rsp_frame_slot   = out_ff.frame_slot;
   assign rsp_command      = out_ff.command;
   assign rsp_read_byte    = out_byte_ff;

`ifndef SYNTHESIS
   // The current slot is never one that a finished frame has claimed.
   a_current_slot_free: assert property (@(posedge clock) disable iff (reset)
      !used_ff[slot_ff])
      else $error("current slot is marked used");

   // While hunting no frame length may be pending.
   a_hunt_no_total: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 9'd0) |-> (total_ff == 9'd0))
      else $error("frame length pending while hunting");

   // Once the length is known the byte count stays below the frame total.
   a_count_below_total: assert property (@(posedge clock) disable iff (reset)
      (total_ff != 9'd0) |-> (count_ff < total_ff))
      else $error("byte count reached frame total");

   // A stalled middle stage blocks new requests and keeps its result.
   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_free) |=> (mid_valid_ff && $stable(mid_ff)))
      else $error("middle stage lost a result");

   // Only read results carry a stored byte.
   a_read_byte_only_for_reads: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.status != ST_READ_DATA)) |-> (out_byte_ff == 8'd0))
      else $error("read byte set on a frame result");
`endif

endmodule

/* test/tb_xor_checked_dual_frame_deframer_unit.sv */
// Self-checking testbench for the dual frame deframer: frame and read requests, result checking.
// Depends on xcdfd_pkg and xor_checked_dual_frame_deframer_unit.
// Stimulus is queued by an initial block, driven by a clocked driver and checked by a monitor.
`timescale 1ns / 1ps

module tb_xor_checked_dual_frame_deframer_unit;
   import xcdfd_pkg::*;

   localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT;
   localparam int CONTROL_MAX = CONTROL_MAX_DEFAULT;
   localparam int SLOT_COUNT  = SLOT_COUNT_DEFAULT;
   localparam int SLOT_BYTES  = MAX_PAYLOAD + DATA_OVERHEAD;
   localparam int STORE_BYTES = SLOT_COUNT * SLOT_BYTES;
   // An unknown request kind, which the block must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Length of the forced receiver hold-off, and the run's cycle budget.
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [1:0] read_slot;
      logic [7:0] read_offset;
   } req_item_t;

   typedef struct {
      status_type  status;
      logic [31:0] dest_address;
      logic [15:0] program_id;
      logic [7:0]  payload_len;
      logic [1:0]  frame_slot;
      logic [7:0]  command;
      logic [7:0]  read_byte;
   } rsp_item_t;

   // Every input of the block starts from a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_rx_byte = '0;
   logic [1:0]  req_read_slot = '0;
   logic [7:0]  req_read_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_dest_address;
   logic [15:0] rsp_program_id;
   logic [7:0]  rsp_payload_len;
   logic [1:0]  rsp_frame_slot;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_read_byte;

   xor_checked_dual_frame_deframer_unit #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .CONTROL_MAX (CONTROL_MAX),
      .SLOT_COUNT  (SLOT_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .req_read_slot    (req_read_slot),
      .req_read_offset  (req_read_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_dest_address (rsp_dest_address),
      .rsp_program_id   (rsp_program_id),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_frame_slot   (rsp_frame_slot),
      .rsp_command      (rsp_command),
      .rsp_read_byte    (rsp_read_byte)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Requests waiting to be driven, and the results that accepted requests are owed.
   req_item_t req_queue[$];
   rsp_item_t awaited_results[$];
   req_item_t next_req;
   req_item_t seen_req;
   rsp_item_t got_rsp;

   int  queued_count = 0;
   int  taken_count = 0;
   int  failures = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_req = 1'b0;
   bit  hold_ack = 1'b0;
   int  hold_left = 0;

   // Shadow of the deframer: parser registers, slot bookkeeping and the slot store.
   // The written map records which store bytes hold a defined value, so that reads
   // are only ever aimed at bytes that some frame has filled in.
   logic [1:0]  cur_slot = '0;
   logic [3:0]  used_mask = '0;
   int          frame_pos = 0;
   int          frame_total = 0;
   bit          in_ctrl = 1'b0;
   logic [7:0]  run_sum = '0;
   logic [31:0] hdr_address = '0;
   logic [15:0] hdr_program = '0;
   logic [7:0]  hdr_length = '0;
   logic [7:0]  hdr_command = '0;
   logic [7:0]  slot_store [0:STORE_BYTES-1];
   bit          written [0:STORE_BYTES-1];

   function automatic void keep_byte(int pos, logic [7:0] b);
      // Bytes past the end of a slot still count towards the frame but are not kept.
      if (pos < SLOT_BYTES) begin
         slot_store[cur_slot * SLOT_BYTES + pos] = b;
         written[cur_slot * SLOT_BYTES + pos] = 1'b1;
      end
   endfunction

   function automatic rsp_item_t frame_result(status_type st);
      rsp_item_t res;
      res.status       = st;
      res.dest_address = in_ctrl ? 32'd0 : hdr_address;
      res.program_id   = in_ctrl ? 16'd0 : hdr_program;
      res.payload_len  = hdr_length;
      res.frame_slot   = cur_slot;
      res.command      = in_ctrl ? hdr_command : 8'd0;
      res.read_byte    = 8'd0;
      return res;
   endfunction

   // Advances the shadow by one accepted request and queues the result it owes, if any.
   function automatic void track_request(req_item_t r);
      rsp_item_t  res;
      int         pos;
      int         bound;
      int         i;
      bit         produced;
      logic [7:0] b;
      produced = 1'b0;
      b = r.rx_byte;
      case (r.kind)
         KIND_BYTE: begin
            pos = frame_pos;
            if (pos == 0) begin
               // Hunting: only a start byte opens a frame, anything else is dropped.
               if (b == START_DATA || b == START_CTRL) begin
                  in_ctrl     = (b == START_CTRL);
                  run_sum     = '0;
                  frame_total = 0;
                  hdr_address = '0;
                  hdr_program = '0;
                  hdr_length  = '0;
                  hdr_command = '0;
                  keep_byte(0, b);
                  frame_pos = 1;
               end
            end else begin
               keep_byte(pos, b);
               frame_pos = pos + 1;
               if (frame_total == 0) begin
                  // Still inside the header; the length byte fixes the frame total.
                  if (!in_ctrl) begin
                     if (pos >= 1 && pos <= 4) begin
                        hdr_address[8 * (pos - 1) +: 8] = b;
                     end else if (pos == 5 || pos == 6) begin
                        hdr_program[8 * (pos - 5) +: 8] = b;
                     end else if (pos == 8) begin
                        hdr_length  = b;
                        frame_total = DATA_OVERHEAD + b;
                     end
                  end else begin
                     if (pos == 1) begin
                        hdr_command = b;
                     end else if (pos == 2) begin
                        hdr_length  = b;
                        frame_total = CTRL_OVERHEAD + b;
                     end
                  end
                  run_sum ^= b;
                  if (frame_total != 0) begin
                     bound = in_ctrl ? CTRL_OVERHEAD + CONTROL_MAX : DATA_OVERHEAD + MAX_PAYLOAD;
                     if (frame_total > bound) begin
                        res = frame_result(ST_TOO_LONG);
                        produced = 1'b1;
                        frame_pos = 0;
                        frame_total = 0;
                     end
                  end
               end else if (frame_pos < frame_total) begin
                  run_sum ^= b;
               end else begin
                  // This is the checksum byte, so the frame is complete.
                  frame_pos = 0;
                  frame_total = 0;
                  produced = 1'b1;
                  if (run_sum != b) begin
                     res = frame_result(ST_BAD_SUM);
                  end else if (in_ctrl) begin
                     res = frame_result(ST_CTRL_READY);
                  end else begin
                     used_mask[cur_slot] = 1'b1;
                     i = 0;
                     while (i < SLOT_COUNT && used_mask[i]) begin
                        i++;
                     end
                     if (i < SLOT_COUNT) begin
                        res = frame_result(ST_DATA_READY);
                        cur_slot = 2'(i);
                     end else begin
                        // No slot is free: the claim is undone and the slot is reused.
                        used_mask[cur_slot] = 1'b0;
                        res = frame_result(ST_NO_SLOT);
                     end
                  end
               end
            end
         end
         KIND_RELEASE: begin
            used_mask = '0;
         end
         KIND_READ: begin
            res.status       = ST_READ_DATA;
            res.dest_address = '0;
            res.program_id   = '0;
            res.payload_len  = '0;
            res.frame_slot   = '0;
            res.command      = '0;
            if (r.read_slot < SLOT_COUNT && r.read_offset < SLOT_BYTES) begin
               res.read_byte = slot_store[r.read_slot * SLOT_BYTES + r.read_offset];
            end else begin
               res.read_byte = '0;
            end
            produced = 1'b1;
         end
         default: begin
         end
      endcase
      if (produced) begin
         awaited_results.push_back(res);
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         failures++;
      end
   endfunction

   // Driver. A new request is presented at the falling edge once the previous one has
   // been taken; a request that is still waiting keeps its payload untouched.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = req_queue.pop_front();
            req_valid       <= 1'b1;
            req_kind        <= next_req.kind;
            req_rx_byte     <= next_req.rx_byte;
            req_read_slot   <= next_req.read_slot;
            req_read_offset <= next_req.read_offset;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. A hold-off asked for by the stimulus is counted down here, in cycles;
   // otherwise ready is withdrawn at random according to the current idling rate.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor. At each rising edge an accepted request advances the shadow, and an
   // accepted result is compared field by field with the oldest one owed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         req_taken = !reset && req_valid && req_ready;
         if (req_taken) begin
            seen_req.kind        = req_kind;
            seen_req.rx_byte     = req_rx_byte;
            seen_req.read_slot   = req_read_slot;
            seen_req.read_offset = req_read_offset;
            track_request(seen_req);
            taken_count++;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result with status %0d arrived while none was owed", rsp_status);
               failures++;
            end else begin
               got_rsp = awaited_results.pop_front();
               check_field("status", got_rsp.status, rsp_status);
               check_field("dest_address", got_rsp.dest_address, rsp_dest_address);
               check_field("program_id", got_rsp.program_id, rsp_program_id);
               check_field("payload_len", got_rsp.payload_len, rsp_payload_len);
               check_field("frame_slot", got_rsp.frame_slot, rsp_frame_slot);
               check_field("command", got_rsp.command, rsp_command);
               check_field("read_byte", got_rsp.read_byte, rsp_read_byte);
            end
         end
      end
   end

   task automatic push_req(logic [1:0] kind, logic [7:0] rx, logic [1:0] rslot,
                           logic [7:0] roff);
      req_item_t item;
      item.kind        = kind;
      item.rx_byte     = rx;
      item.read_slot   = rslot;
      item.read_offset = roff;
      req_queue.push_back(item);
      queued_count++;
   endtask

   // A received byte; the unused read fields carry random junk.
   task automatic send_byte(logic [7:0] b);
      push_req(KIND_BYTE, b, 2'($urandom), 8'($urandom));
   endtask

   task automatic wait_accepted();
      while (taken_count != queued_count) begin
         @(negedge clock);
      end
   endtask

   // Everything taken and every owed result delivered, then the pipeline is left to drain.
   task automatic wait_quiet();
      wait_accepted();
      while (awaited_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   // A data frame. A length over the bound stops after the length byte, since the
   // block abandons the frame there; a bad checksum is flipped by a non-zero mask.
   task automatic send_data_frame(logic [31:0] addr, logic [15:0] prog, int len, bit bad_sum);
      logic [7:0] b;
      logic [7:0] sum;
      sum = '0;
      send_byte(START_DATA);
      for (int i = 0; i < 4; i++) begin
         b = addr[8 * i +: 8];
         send_byte(b);
         sum ^= b;
      end
      for (int i = 0; i < 2; i++) begin
         b = prog[8 * i +: 8];
         send_byte(b);
         sum ^= b;
      end
      b = 8'($urandom);
      send_byte(b);
      sum ^= b;
      b = 8'(len);
      send_byte(b);
      sum ^= b;
      if (len <= MAX_PAYLOAD) begin
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            send_byte(b);
            sum ^= b;
         end
         if (bad_sum) begin
            sum ^= 8'($urandom_range(255, 1));
         end
         send_byte(sum);
      end
   endtask

   task automatic send_ctrl_frame(logic [7:0] cmd, int len, bit bad_sum);
      logic [7:0] b;
      logic [7:0] sum;
      send_byte(START_CTRL);
      send_byte(cmd);
      b = 8'(len);
      send_byte(b);
      sum = cmd ^ b;
      if (len <= CONTROL_MAX) begin
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            send_byte(b);
            sum ^= b;
         end
         if (bad_sum) begin
            sum ^= 8'($urandom_range(255, 1));
         end
         send_byte(sum);
      end
   endtask

   // A read is queued only once every earlier request has been taken, so the written
   // map is up to date. Bytes never filled are avoided; failing that, the offset is
   // pushed past the end of the slot, where the block answers zero.
   task automatic send_read_any();
      int s;
      int o;
      int tries;
      wait_accepted();
      s = $urandom_range(SLOT_COUNT - 1);
      o = ($urandom_range(1) == 0) ? $urandom_range(12) : $urandom_range(SLOT_BYTES - 1);
      if ($urandom_range(3) == 0) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            if (written[k * SLOT_BYTES + SLOT_BYTES - 1]) begin
               s = k;
               o = SLOT_BYTES - 1;
            end
         end
      end
      tries = 0;
      while (!written[s * SLOT_BYTES + o] && tries < 40) begin
         s = $urandom_range(SLOT_COUNT - 1);
         o = $urandom_range(20);
         tries++;
      end
      if (!written[s * SLOT_BYTES + o] || $urandom_range(19) == 0) begin
         o = $urandom_range(255, SLOT_BYTES);
      end
      push_req(KIND_READ, 8'($urandom), 2'(s), 8'(o));
   endtask

   // Mostly short frames, now and then the longest that the bound allows.
   function automatic int pick_len(int longest);
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         return longest;
      end else if (r < 80) begin
         return $urandom_range(6);
      end
      return $urandom_range((longest < 24) ? longest : 24);
   endfunction

   // Random traffic: mostly well-formed frames with random content, mixed with bad
   // checksums, over-long lengths, reads, releases, unknown kinds and line noise.
   task automatic run_random(int budget);
      int  done;
      int  pick;
      int  before_cnt;
      bit  counts;
      logic [7:0] b;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(99);
         before_cnt = queued_count;
         counts = 1'b1;
         if (pick < 36) begin
            send_data_frame($urandom, 16'($urandom), pick_len(MAX_PAYLOAD), 1'b0);
         end else if (pick < 56) begin
            send_ctrl_frame(8'($urandom), pick_len(CONTROL_MAX), 1'b0);
         end else if (pick < 62) begin
            send_data_frame($urandom, 16'($urandom), $urandom_range(8), 1'b1);
         end else if (pick < 66) begin
            send_ctrl_frame(8'($urandom), $urandom_range(8), 1'b1);
         end else if (pick < 70) begin
            if ($urandom_range(1) == 0) begin
               send_data_frame($urandom, 16'($urandom), $urandom_range(255, MAX_PAYLOAD + 1),
                               1'b0);
            end else begin
               send_ctrl_frame(8'($urandom), $urandom_range(255, CONTROL_MAX + 1), 1'b0);
            end
         end else if (pick < 84) begin
            send_read_any();
         end else if (pick < 90) begin
            push_req(KIND_RELEASE, 8'($urandom), 2'($urandom), 8'($urandom));
            counts = 1'b0;
         end else if (pick < 92) begin
            push_req(KIND_UNUSED, 8'($urandom), 2'($urandom), 8'($urandom));
            counts = 1'b0;
         end else begin
            // Line noise between frames. Now and then it carries a start byte, which
            // opens a broken frame that swallows whatever follows.
            for (int i = $urandom_range(2); i >= 0; i--) begin
               b = 8'($urandom);
               if ((b == START_DATA || b == START_CTRL) && $urandom_range(7) != 0) begin
                  b = ~b;
               end
               send_byte(b);
            end
            counts = 1'b0;
         end
         if (counts) begin
            done += queued_count - before_cnt;
         end
      end
   endtask

   initial begin
      // Synchronous reset, released at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 75;

      // Directed part. Bytes other than a start byte are ignored while hunting, as is
      // an unknown kind with every field bit set.
      send_byte(8'h00);
      send_byte(8'hFF);
      push_req(KIND_UNUSED, 8'hFF, 2'b11, 8'hFF);
      // A good control frame with the largest command and no data, then a good data
      // frame with every address and program bit set, which claims slot zero.
      send_ctrl_frame(8'hFF, 0, 1'b0);
      send_data_frame(32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0);
      // A random read, then read back the start byte and the checksum of slot zero, then a read beyond the slot.
      send_read_any();
      wait_accepted();
      push_req(KIND_READ, 8'h00, 2'd0, 8'd0);
      push_req(KIND_READ, 8'h00, 2'd0, 8'd9);
      push_req(KIND_READ, 8'h00, 2'd3, 8'hFF);
      push_req(KIND_RELEASE, 8'h00, 2'd0, 8'd0);
      // A control length one above the bound, and a control frame with a bad checksum.
      send_ctrl_frame(8'h00, CONTROL_MAX + 1, 1'b0);
      send_ctrl_frame(8'h5A, 1, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) begin
            // Fill every slot, so that further good data frames find none free.
            repeat (SLOT_COUNT + 1) send_data_frame($urandom, 16'($urandom), 0, 1'b0);
            send_read_any();
            push_req(KIND_RELEASE, 8'($urandom), 2'($urandom), 8'($urandom));
         end else if (phase == 1) begin
            wait_quiet();
            send_idle_pct = 75;
            recv_idle_pct = 28;
            // The longest control frame that the bound allows.
            send_ctrl_frame(8'($urandom), CONTROL_MAX, 1'b0);
         end else begin
            // No idling at all. The receiver stalls for a long stretch first, while a
            // burst of short control frames keeps the sender offering requests, so the
            // block fills up and pushes back on its input.
            wait_quiet();
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_req = ~hold_req;
            repeat (12) send_ctrl_frame(8'($urandom), 0, 1'b0);
            // The longest data frame that the bound allows, sent back to back.
            send_data_frame($urandom, 16'($urandom), MAX_PAYLOAD, 1'b0);
         end
         // Over-long data lengths in every phase.
         send_read_any();
         send_data_frame($urandom, 16'($urandom), 255, 1'b0);
         send_data_frame($urandom, 16'($urandom), MAX_PAYLOAD + 1, 1'b0);
         run_random(24);
      end

      wait_quiet();
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/xcdfd_pkg.sv
hdl/xor_checked_dual_frame_deframer_unit.sv
test/tb_xor_checked_dual_frame_deframer_unit.sv
